// File: rtl/fasm_pkg.sv
// Shared types and constants for the forward advection source map.
// Used by fasm_ctrl, fasm_dpath and forward_advection_source_map_unit.
package fasm_pkg;

    localparam int DEF_ROWS  = 256;
    localparam int DEF_COLS  = 256;
    localparam int GRID_MAX  = 256;   // row/col fields are 8 bits wide
    localparam int FRAC_BITS = 12;    // Q8.8 * Q11.4 product is Q.12
    localparam int ENTRY_W   = 17;    // {flag, source row, source col}

    localparam logic signed [15:0] TIME_STEP_RESET = 16'sd256;
    localparam logic        [8:0]  LIMIT_RESET     = 9'd256;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_SCATTER = 2'd1,
        MODE_READ    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_TIME_STEP = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_COLS      = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MUL,
        S_QUO,
        S_MEM,
        S_CLR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic quo_en;
        logic mem_op;
        logic clr_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  clr_last;
    } t_sts;

endpackage

// File: rtl/fasm_ctrl.sv
// Sequencer of the source map: steps one item through multiply, bounds,
// memory access and output, and runs the clear walk. Depends on fasm_pkg.
module fasm_ctrl import fasm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_m_tvalid;
    logic   out_free;

    assign out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_s_tvalid) n_state = S_MUL;
            S_MUL:  n_state = S_QUO;
            S_QUO:  n_state = (i_sts.mode == MODE_CLEAR) ? S_CLR : S_MEM;
            S_MEM:  n_state = S_OUT;
            S_CLR:  if (i_sts.clr_last) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_INIT: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_s_tready     = 1'b1;
                o_cmd.load_in  = i_s_tvalid;
            end
            S_MUL:  o_cmd.mul_en   = 1'b1;
            S_QUO:  o_cmd.quo_en   = 1'b1;
            S_MEM:  o_cmd.mem_op   = 1'b1;
            S_CLR:  o_cmd.clr_step = 1'b1;
            S_OUT:  o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_tvalid;

endmodule

// File: rtl/fasm_dpath.sv
// Datapath of the source map: config registers, advection arithmetic,
// cell memory with clear walk, and the output register. Depends on fasm_pkg.
module fasm_dpath import fasm_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [47:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_m_tdata,
    output logic [1:0]  o_m_tuser
);

    localparam int MROWS  = (ROWS < GRID_MAX) ? ROWS : GRID_MAX;
    localparam int MCOLS  = (COLS < GRID_MAX) ? COLS : GRID_MAX;
    localparam int MDEPTH = MROWS * MCOLS;
    localparam int AW     = $clog2(MDEPTH);

    // configuration
    logic signed [15:0] r_time_step;
    logic        [8:0]  r_rows_in_use, r_cols_in_use;
    logic        [8:0]  rlim, clim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= TIME_STEP_RESET;
            r_rows_in_use <= LIMIT_RESET;
            r_cols_in_use <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_STEP: r_time_step   <= i_cfg_data;
                CFG_ROWS:      r_rows_in_use <= i_cfg_data[8:0];
                CFG_COLS:      r_cols_in_use <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign rlim = (r_rows_in_use > 9'(MROWS)) ? 9'(MROWS) : r_rows_in_use;
    assign clim = (r_cols_in_use > 9'(MCOLS)) ? 9'(MCOLS) : r_cols_in_use;

    // item registers
    t_mode              r_mode;
    logic        [7:0]  r_row, r_col;
    logic signed [15:0] r_drow, r_dcol;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= t_mode'(i_s_tuser);
            r_row  <= i_s_tdata[7:0];
            r_col  <= i_s_tdata[15:8];
            r_drow <= i_s_tdata[31:16];
            r_dcol <= i_s_tdata[47:32];
        end
    end

    // products and source bounds
    logic signed [31:0] r_prod_r, r_prod_c;
    logic               r_src_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_r <= r_time_step * r_drow;
            r_prod_c <= r_time_step * r_dcol;
            r_src_ok <= ({1'b0, r_row} < rlim) && ({1'b0, r_col} < clim);
        end
    end

    // Truncation toward zero: dest in [0, lim) iff -4096 < sum < lim * 4096,
    // and a sum in (-4096, 0] lands on 0.
    logic signed [33:0] sum_r, sum_c;
    logic               in_r, in_c;
    logic               r_land;
    logic        [7:0]  r_dest_row, r_dest_col;

    assign sum_r = $signed({14'd0, r_row, {FRAC_BITS{1'b0}}}) + 34'(r_prod_r);
    assign sum_c = $signed({14'd0, r_col, {FRAC_BITS{1'b0}}}) + 34'(r_prod_c);
    assign in_r  = (sum_r > -34'sd4096) && (sum_r < $signed({13'd0, rlim, 12'd0}));
    assign in_c  = (sum_c > -34'sd4096) && (sum_c < $signed({13'd0, clim, 12'd0}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.quo_en) begin
            r_land     <= r_src_ok && in_r && in_c;
            r_dest_row <= sum_r[33] ? 8'd0 : sum_r[19:12];
            r_dest_col <= sum_c[33] ? 8'd0 : sum_c[19:12];
        end
    end

    // cell memory: {flag, source row, source col}
    logic [ENTRY_W-1:0] mem [MDEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [AW-1:0]      r_clr_idx;
    logic [AW-1:0]      cell_addr, mem_addr;
    logic [7:0]         a_row, a_col;
    logic               clr_last, mem_we, mem_re;
    logic [ENTRY_W-1:0] mem_wdata;

    assign a_row     = (r_mode == MODE_SCATTER) ? r_dest_row : r_row;
    assign a_col     = (r_mode == MODE_SCATTER) ? r_dest_col : r_col;
    assign cell_addr = AW'(int'(a_row) * MCOLS + int'(a_col));
    assign clr_last  = (r_clr_idx == AW'(MDEPTH - 1));
    assign mem_we    = i_cmd.clr_step || (i_cmd.mem_op && r_mode == MODE_SCATTER && r_land);
    assign mem_re    = i_cmd.mem_op && r_mode == MODE_READ && r_src_ok;
    assign mem_addr  = i_cmd.clr_step ? r_clr_idx : cell_addr;
    assign mem_wdata = i_cmd.clr_step ? '0 : {1'b1, r_row, r_col};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[cell_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= clr_last ? '0 : r_clr_idx + 1'b1;
        end
    end

    // output register
    logic       r_out_landed, r_out_occ;
    logic [7:0] r_out_drow, r_out_dcol, r_out_srow, r_out_scol;
    logic       landed, occ;

    assign landed = (r_mode == MODE_SCATTER) && r_land;
    assign occ    = (r_mode == MODE_READ) && r_src_ok && r_rdata[ENTRY_W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_landed <= landed;
            r_out_occ    <= occ;
            r_out_drow   <= landed ? r_dest_row : 8'd0;
            r_out_dcol   <= landed ? r_dest_col : 8'd0;
            r_out_srow   <= occ ? r_rdata[15:8] : 8'd0;
            r_out_scol   <= occ ? r_rdata[7:0] : 8'd0;
        end
    end

    assign o_m_tdata      = {r_out_scol, r_out_srow, r_out_dcol, r_out_drow};
    assign o_m_tuser      = {r_out_occ, r_out_landed};
    assign o_sts.mode     = r_mode;
    assign o_sts.clr_last = clr_last;

endmodule

// File: rtl/forward_advection_source_map_unit.sv
// Top level of the forward advection source map.
// Instantiates fasm_ctrl and fasm_dpath; depends on fasm_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready| tuser: mode; tdata: cell, disp
//  m       | out | o_m_tvalid/i_m_tready| tuser: landed, occupied; tdata: cells
//  cfg     | in  | i_cfg_valid/o_cfg_ready | index 0 dt, 1 rows, 2 cols
//
// Scatter, read and unused-mode items each pass through input latch,
// multiply, bounds, memory access and output load.
// A clear item walks the cell memory, one entry a cycle, all MROWS*MCOLS entries
// (65536 at defaults). Reset starts the same walk; no item is taken
// until it ends. A result held on m stalls only the output-load step.
module forward_advection_source_map_unit import fasm_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // cell_row, cell_col, disp_row, disp_col
    input  logic [1:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // dest_row, dest_col, source_row, source_col
    output logic [1:0]  o_m_tuser,   // landed, occupied
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    fasm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fasm_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("output register loaded over a pending result");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("result both landed and occupied");

    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[15:0] == 16'd0))
        else $error("destination nonzero without landing");

endmodule
